/* hw/rtl/vap_pkg.sv */
// Shared types, constants and codes of the activity picker.
package vap_pkg;

  localparam int MAX_VARS_DEF    = 256;
  localparam int SCORE_WIDTH_DEF = 40;
  localparam int FRAC_BITS       = 16;
  localparam int RESCALE_SHIFT   = 24;
  localparam int DECAY_W         = 18;
  localparam int AVARS_W         = 9;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 18;

  localparam logic [63:0]          RESCALE_LIMIT     = 64'h0000_0040_0000_0000;
  localparam logic [63:0]          INC_RESET         = 64'd65536;
  localparam logic [AVARS_W-1:0]   ACTIVE_VARS_RESET = 9'd256;
  localparam logic [DECAY_W-1:0]   DECAY_RECIP_RESET = 18'd68985;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VARS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RECIP = 1'b1;

  typedef enum logic [1:0] {
    OP_BUMP     = 2'd0,
    OP_DECAY    = 2'd1,
    OP_PICK     = 2'd2,
    OP_SET_MARK = 2'd3
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] var_index;
    logic       assigned_flag;
  } in_item_t;

  typedef struct packed {
    logic [7:0] picked_var;
    logic       found;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_RESCALE,
    ST_DECAY,
    ST_DECAY_FIN,
    ST_PICK,
    ST_PICK_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clear_step;
    logic mark_write;
    logic bump_read;
    logic bump_write;
    logic inc_shift;
    logic sweep_start;
    logic sweep_run;
    logic sweep_pick;
    logic decay_start;
    logic decay_step;
    logic decay_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic clear_last;
    logic bump_ok;
    logic bump_over;
    logic sweep_done;
    logic decay_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/vap_ctrl.sv */
// Controller state machine of the activity picker.
module vap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vap_pkg::dp_stat_t stat,
  output vap_pkg::dp_cmd_t  cmd
);
  import vap_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_BUMP: state_nxt = stat.bump_ok ? ST_BUMP_RD : ST_IDLE;
          OP_DECAY: begin
            cmd.decay_start = 1'b1;
            state_nxt       = ST_DECAY;
          end
          OP_PICK: begin
            cmd.sweep_start = 1'b1;
            state_nxt       = ST_PICK;
          end
          OP_SET_MARK: begin
            cmd.mark_write = 1'b1;
            state_nxt      = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_BUMP_RD: begin
        cmd.bump_read = 1'b1;
        state_nxt     = ST_BUMP_WR;
      end
      ST_BUMP_WR: begin
        cmd.bump_write = 1'b1;
        if (stat.bump_over) begin
          cmd.inc_shift   = 1'b1;
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_RESCALE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESCALE: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) state_nxt = ST_IDLE;
      end
      ST_DECAY: begin
        cmd.decay_step = 1'b1;
        if (stat.decay_last) state_nxt = ST_DECAY_FIN;
      end
      ST_DECAY_FIN: begin
        cmd.decay_fin = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_PICK: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_pick = 1'b1;
        if (stat.sweep_done) state_nxt = ST_PICK_OUT;
      end
      ST_PICK_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

/* hw/rtl/vap_dpath.sv */
// Datapath: score and mark memories, increment, decay multiplier, scan and output register.
module vap_dpath #(
  parameter int MAX_VARS    = vap_pkg::MAX_VARS_DEF,
  parameter int SCORE_WIDTH = vap_pkg::SCORE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  vap_pkg::in_item_t                in_data,
  input  vap_pkg::dp_cmd_t                 cmd,
  output vap_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vap_pkg::out_item_t               out_data
);
  import vap_pkg::*;

  localparam int IDX_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int LIM_W  = (CNT_W > AVARS_W) ? CNT_W : AVARS_W;
  localparam int NCH    = (SCORE_WIDTH + FRAC_BITS - 1) / FRAC_BITS;
  localparam int KW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W  = NCH * FRAC_BITS;
  localparam int PROD_W = FRAC_BITS + DECAY_W;
  localparam int ACC_W  = PAD_W + DECAY_W;
  localparam int HI_W   = ACC_W - FRAC_BITS;
  localparam logic [SCORE_WIDTH-1:0] SCORE_MAX = '1;

  logic [SCORE_WIDTH-1:0] score_mem [MAX_VARS];
  logic                   mark_mem  [MAX_VARS];

  logic [AVARS_W-1:0]     active_vars_r;
  logic [DECAY_W-1:0]     decay_recip_r;
  in_item_t               item_r;
  logic [SCORE_WIDTH-1:0] inc_r, inc_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pipe_v_r, pipe_v_nxt;
  logic [IDX_W-1:0]       pipe_addr_r;
  logic                   have_r, have_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [SCORE_WIDTH-1:0] best_act_r, best_act_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [SCORE_WIDTH-1:0] score_rd_r;
  logic                   mark_rd_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r;

  logic [IDX_W-1:0]       item_idx, rd_addr, score_waddr, mark_waddr;
  logic [LIM_W-1:0]       lim, sweep_lim;
  logic                   rd_more, pipe_last, take_best, bump_ok, set_ok;
  logic [SCORE_WIDTH:0]   bump_full;
  logic [SCORE_WIDTH-1:0] bump_sum, shifted, dec_val, score_wdata;
  logic                   bump_over, score_we, mark_we, mark_wdata;
  logic [PAD_W-1:0]       inc_pad;
  logic [FRAC_BITS-1:0]   chunk;
  logic [PROD_W-1:0]      part;
  logic [HI_W-1:0]        acc_hi;

  assign item_idx  = IDX_W'(item_r.var_index);
  assign lim       = (LIM_W'(active_vars_r) < LIM_W'(MAX_VARS)) ?
                     LIM_W'(active_vars_r) : LIM_W'(MAX_VARS);
  assign sweep_lim = (item_r.opcode == OP_PICK) ? lim : LIM_W'(MAX_VARS);
  assign rd_more   = LIM_W'(cnt_r) < sweep_lim;
  assign pipe_last = (LIM_W'(pipe_addr_r) + LIM_W'(1)) == sweep_lim;
  assign bump_ok   = (LIM_W'(item_r.var_index) < LIM_W'(active_vars_r)) &&
                     (32'(item_r.var_index) < 32'(MAX_VARS));
  assign set_ok    = 32'(item_r.var_index) < 32'(MAX_VARS);

  assign bump_full = {1'b0, score_rd_r} + {1'b0, inc_r};
  assign bump_sum  = bump_full[SCORE_WIDTH] ? SCORE_MAX : bump_full[SCORE_WIDTH-1:0];
  assign bump_over = 64'(bump_sum) > RESCALE_LIMIT;
  assign shifted   = SCORE_WIDTH'(64'(score_rd_r) >> RESCALE_SHIFT);
  assign take_best = pipe_v_r && !mark_rd_r && (!have_r || (score_rd_r > best_act_r));

  // decay: inc * recip, one 16-bit chunk of inc per cycle, most significant first
  assign inc_pad = PAD_W'(inc_r);
  assign chunk   = inc_pad[k_r*FRAC_BITS +: FRAC_BITS];
  assign part    = PROD_W'(chunk) * PROD_W'(decay_recip_r);
  assign acc_nxt = cmd.decay_start ? '0 :
                   cmd.decay_step  ? ((acc_r << FRAC_BITS) + ACC_W'(part)) : acc_r;
  assign k_nxt   = cmd.decay_start ? KW'(NCH - 1) :
                   cmd.decay_step  ? (k_r - KW'(1)) : k_r;
  assign acc_hi  = acc_r[ACC_W-1:FRAC_BITS];
  assign dec_val = (|(acc_hi >> SCORE_WIDTH)) ? SCORE_MAX : SCORE_WIDTH'(acc_hi);

  assign rd_addr = cmd.bump_read ? item_idx : cnt_r[IDX_W-1:0];

  always_comb begin
    score_we    = 1'b0;
    score_waddr = cnt_r[IDX_W-1:0];
    score_wdata = '0;
    if (cmd.clear_step) begin
      score_we = 1'b1;
    end else if (cmd.bump_write) begin
      score_we    = 1'b1;
      score_waddr = item_idx;
      score_wdata = bump_sum;
    end else if (cmd.sweep_run && !cmd.sweep_pick && pipe_v_r) begin
      score_we    = 1'b1;
      score_waddr = pipe_addr_r;
      score_wdata = shifted;
    end
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = cnt_r[IDX_W-1:0];
    mark_wdata = 1'b0;
    if (cmd.clear_step) begin
      mark_we = 1'b1;
    end else if (cmd.mark_write && set_ok) begin
      mark_we    = 1'b1;
      mark_waddr = item_idx;
      mark_wdata = item_r.assigned_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (score_we) score_mem[score_waddr] <= score_wdata;
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    score_rd_r <= score_mem[rd_addr];
    mark_rd_r  <= mark_mem[rd_addr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.sweep_start) begin
      cnt_nxt = '0;
    end else if (cmd.sweep_run && rd_more) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign pipe_v_nxt = cmd.sweep_run && rd_more;

  always_comb begin
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_act_nxt = best_act_r;
    if (cmd.sweep_start) begin
      have_nxt     = 1'b0;
      best_idx_nxt = '0;
      best_act_nxt = '0;
    end else if (cmd.sweep_run && cmd.sweep_pick && take_best) begin
      have_nxt     = 1'b1;
      best_idx_nxt = pipe_addr_r;
      best_act_nxt = score_rd_r;
    end
  end

  always_comb begin
    inc_nxt = inc_r;
    if (cmd.inc_shift) begin
      inc_nxt = SCORE_WIDTH'(64'(inc_r) >> RESCALE_SHIFT);
    end else if (cmd.decay_fin) begin
      inc_nxt = dec_val;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_vars_r <= ACTIVE_VARS_RESET;
      decay_recip_r <= DECAY_RECIP_RESET;
      inc_r         <= SCORE_WIDTH'(INC_RESET);
      cnt_r         <= '0;
      pipe_v_r      <= 1'b0;
      have_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_ACTIVE_VARS)) active_vars_r <= cfg_wdata[AVARS_W-1:0];
      if (cfg_we && (cfg_index == CFG_DECAY_RECIP)) decay_recip_r <= cfg_wdata[DECAY_W-1:0];
      inc_r       <= inc_nxt;
      cnt_r       <= cnt_nxt;
      pipe_v_r    <= pipe_v_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_data;
    pipe_addr_r <= cnt_r[IDX_W-1:0];
    best_idx_r  <= best_idx_nxt;
    best_act_r  <= best_act_nxt;
    acc_r       <= acc_nxt;
    k_r         <= k_nxt;
    if (cmd.out_load) begin
      out_data_r.found      <= have_r;
      out_data_r.picked_var <= have_r ? 8'(best_idx_r) : 8'd0;
    end
  end

  always_comb begin
    stat.op         = item_r.opcode;
    stat.clear_last = (cnt_r == CNT_W'(MAX_VARS - 1));
    stat.bump_ok    = bump_ok;
    stat.bump_over  = bump_over;
    stat.sweep_done = (sweep_lim == '0) || (pipe_v_r && pipe_last);
    stat.decay_last = (k_r == '0);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/vsids_activity_picker.sv */
// Top level of the VSIDS activity picker: controller plus datapath.
//
//   channel  ports                              role
//   in       in_valid, in_stall, in_data        opcode, var_index, assigned_flag
//   out      out_valid, out_stall, out_data     picked_var, found (pick only)
//   cfg      cfg_we, cfg_index, cfg_wdata       0 active_vars, 1 decay_reciprocal
//
// Transactions: set-mark writes the mark memory; bump reads and writes the score, and a bump
// over the rescale limit then makes one pass over the score memory; decay does one 16x18
// multiply per chunk, ceil(SCORE_WIDTH/16) chunks; pick reads min(active_vars, MAX_VARS) scores.
// After reset a clearing pass over all MAX_VARS entries zeroes the memories; in_stall stays high.
// A finished pick waits in the output register; the next transaction is taken meanwhile,
// and a second pick holds at its end until the output register is free.
module vsids_activity_picker #(
  parameter int MAX_VARS    = vap_pkg::MAX_VARS_DEF,
  parameter int SCORE_WIDTH = vap_pkg::SCORE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vap_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vap_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [vap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vap_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vap_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vap_dpath #(
    .MAX_VARS    (MAX_VARS),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/vap_checker.sv */
// Port-level assertions of the activity picker and their bind.
module vap_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input vap_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input vap_pkg::out_item_t out_data
);
  import vap_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic       pick_acc, out_acc;

  assign pick_acc = in_valid && !in_stall && (in_data.opcode == OP_PICK);
  assign out_acc  = out_valid && !out_stall;
  assign pend_nxt = pend_r + {1'b0, pick_acc} - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pick_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0) && (pend_r <= 2'd2))
    else $error("result without an outstanding pick");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.picked_var == 8'd0)
    else $error("picked_var nonzero with found low");

endmodule

bind vsids_activity_picker vap_checker u_vap_checker (.*);

/* tb/sv/vsids_pick_checker.sv */
// Checker for the activity picker: tracks scores and marks, predicts picks, compares results.
module vsids_pick_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  vap_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  vap_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [vap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vap_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             failures,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import vap_pkg::*;

  localparam int NVARS = MAX_VARS_DEF;
  localparam int SW    = SCORE_WIDTH_DEF;
  localparam logic [SW-1:0] SCORE_SAT = '1;

  logic [SW-1:0]      activity [NVARS];
  logic               marks [NVARS];
  logic [SW-1:0]      bump_inc;
  logic [AVARS_W-1:0] n_active;
  logic [DECAY_W-1:0] decay_recip;
  out_item_t          picks_due [$];
  out_item_t          want;
  out_item_t          best;
  logic [SW:0]        sum;
  logic [63:0]        prod;
  logic [SW-1:0]      best_score;
  logic               have;
  int                 scan_len;
  int                 fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NVARS; i++) begin
        activity[i] = '0;
        marks[i]    = 1'b0;
      end
      bump_inc    = INC_RESET[SW-1:0];
      n_active    = ACTIVE_VARS_RESET;
      decay_recip = DECAY_RECIP_RESET;
      picks_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          $error("unexpected result: picked_var %0d found %0b",
                 out_data.picked_var, out_data.found);
          fail_count++;
        end else begin
          want = picks_due.pop_front();
          if (out_data.picked_var !== want.picked_var) begin
            $error("picked_var: expected %0d, got %0d", want.picked_var, out_data.picked_var);
            fail_count++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_data.found);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          OP_BUMP: begin
            if (in_data.var_index < n_active) begin
              sum = {1'b0, activity[in_data.var_index]} + {1'b0, bump_inc};
              activity[in_data.var_index] = sum[SW] ? SCORE_SAT : sum[SW-1:0];
              if (64'(activity[in_data.var_index]) > RESCALE_LIMIT) begin
                for (int i = 0; i < NVARS; i++)
                  activity[i] = activity[i] >> RESCALE_SHIFT;
                bump_inc = bump_inc >> RESCALE_SHIFT;
              end
            end
          end
          OP_DECAY: begin
            prod = (64'(bump_inc) * 64'(decay_recip)) >> FRAC_BITS;
            bump_inc = (prod > 64'(SCORE_SAT)) ? SCORE_SAT : prod[SW-1:0];
          end
          OP_SET_MARK: begin
            marks[in_data.var_index] = in_data.assigned_flag;
          end
          default: begin
            // highest score among unassigned active vars, lowest index wins ties
            best       = '0;
            have       = 1'b0;
            best_score = '0;
            scan_len   = (int'(n_active) < NVARS) ? int'(n_active) : NVARS;
            for (int i = 0; i < scan_len; i++) begin
              if (!marks[i] && (!have || activity[i] > best_score)) begin
                have            = 1'b1;
                best.picked_var = 8'(i);
                best_score      = activity[i];
              end
            end
            best.found = have;
            picks_due.push_back(best);
          end
        endcase
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE_VARS: n_active    = cfg_wdata[AVARS_W-1:0];
          CFG_DECAY_RECIP: decay_recip = cfg_wdata[DECAY_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= picks_due.size();
    failures    <= fail_count;
  end

endmodule

/* tb/sv/tb_vsids_activity_picker.sv */
// Testbench top for the activity picker: clock, reset, stimulus, receiver stalls and verdict.
module tb_vsids_activity_picker;
  timeunit 1ns;
  timeprecision 1ps;
  import vap_pkg::*;

  localparam int SETTLE_CYCLES   = MAX_VARS_DEF + 60;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int failures;
  int outstanding;
  int cycles          = 0;
  int cur_active      = MAX_VARS_DEF;
  int hold_offs_asked = 0;
  int hold_offs_done  = 0;
  bit steady          = 1'b0;

  vsids_activity_picker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vsids_pick_checker pick_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_vsids_activity_picker failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send(input in_item_t t);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(input op_t op, input int v, input bit flag);
    in_item_t t;
    t.opcode        = op;
    t.var_index     = 8'(v);
    t.assigned_flag = flag;
    send(t);
  endtask

  // wait for all picks to come back, then let a rescale sweep finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int av, input int recip, input int n, input int decay_pct,
                           input bit squeeze, input bit no_gaps);
    in_item_t t;
    int       r;
    int       span;
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACTIVE_VARS;
    cfg_wdata <= CFG_DATA_W'(av);
    @(posedge clk);
    cfg_index <= CFG_DECAY_RECIP;
    cfg_wdata <= CFG_DATA_W'(recip);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_active = av;
    steady     = no_gaps;
    if (squeeze) hold_offs_asked++;
    span = (cur_active < MAX_VARS_DEF) ? cur_active : MAX_VARS_DEF;
    repeat (n) begin
      r = $urandom_range(0, 99);
      t.assigned_flag = ($urandom_range(0, 2) == 0);
      if (span > 0 && $urandom_range(0, 3) != 0)
        t.var_index = 8'($urandom_range(0, span - 1));
      else
        t.var_index = 8'($urandom_range(0, 255));
      if (r < decay_pct)           t.opcode = OP_DECAY;
      else if (r < decay_pct + 25) t.opcode = OP_PICK;
      else if (r < decay_pct + 45) t.opcode = OP_SET_MARK;
      else                         t.opcode = OP_BUMP;
      send(t);
    end
  endtask

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_offs_done < hold_offs_asked) begin
        hold_offs_done++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ties, marks, bumps at both ends of the index range
    issue(OP_PICK, 0, 1'b0);
    issue(OP_BUMP, 255, 1'b0);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_BUMP, 0, 1'b0);
    issue(OP_BUMP, 0, 1'b0);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_SET_MARK, 0, 1'b1);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_SET_MARK, 255, 1'b1);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_DECAY, 0, 1'b0);
    issue(OP_BUMP, 128, 1'b0);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_SET_MARK, 128, 1'b1);
    issue(OP_SET_MARK, 128, 1'b0);
    issue(OP_PICK, 255, 1'b1);
    issue(OP_BUMP, 170, 1'b1);
    issue(OP_BUMP, 85, 1'b0);
    issue(OP_DECAY, 0, 1'b0);
    issue(OP_DECAY, 0, 1'b0);
    issue(OP_BUMP, 85, 1'b0);
    issue(OP_PICK, 0, 1'b0);
    issue(OP_SET_MARK, 0, 1'b0);
    issue(OP_PICK, 0, 1'b0);

    run_phase(MAX_VARS_DEF, DECAY_RECIP_RESET, 70, 15, 1'b1, 1'b0);
    run_phase(1, 65536, 40, 15, 1'b0, 1'b0);
    // fast growth: increment saturates, bumps rescale
    run_phase(17, 262143, 80, 30, 1'b0, 1'b0);
    run_phase(0, 131072, 30, 15, 1'b0, 1'b0);
    run_phase(511, 131072, 60, 35, 1'b0, 1'b1);
    run_phase($urandom_range(2, 255), $urandom_range(65536, 131072), 70, 20, 1'b0, 1'b0);
    // zero reciprocal: increment collapses to zero for good
    run_phase(MAX_VARS_DEF, 0, 50, 15, 1'b0, 1'b0);

    drain();
    if (failures == 0) begin
      $display("tb_vsids_activity_picker passed");
    end else begin
      $display("tb_vsids_activity_picker failed");
    end
    $finish;
  end

endmodule
